// ===== src/chs_pkg.sv =====
// Shared types and constants for the chained hash set.
// Used by chs_bucket, chs_engine and the top level chained_hash_set.
package chs_pkg;

	localparam int KEY_W       = 31;
	localparam int KIND_W      = 2;
	localparam int DEF_BUCKETS = 16;
	localparam int DEF_POOL    = 64;

	localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
	localparam logic [KIND_W-1:0] KIND_SEARCH = 2'd1;
	localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd2;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [KEY_W-1:0]  key;
	} req_t;

	typedef struct packed {
		logic status;
		logic found;
	} res_t;

endpackage

// ===== src/chs_bucket.sv =====
// Remainder unit: key modulo BUCKETS by reciprocal multiplication.
// Depends on chs_pkg for the key width.
module chs_bucket #(
	parameter int BUCKETS = chs_pkg::DEF_BUCKETS
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [chs_pkg::KEY_W-1:0]   key,
	output logic                        done,
	output logic [$clog2(BUCKETS)-1:0]  rem
);

	localparam int BKT_W = $clog2(BUCKETS);
	// The first remainder estimate lies below 2*BUCKETS, one bit wider than the result.
	localparam int RW    = BKT_W + 1;
	localparam int PW    = chs_pkg::KEY_W + 32;
	// floor(2^32 / BUCKETS); the quotient it gives is exact or one too small.
	localparam logic [31:0]   RECIP  = 32'((64'd1 << 32) / 64'(BUCKETS));
	localparam logic [RW-1:0] DIV_RW = RW'(BUCKETS);

	logic                      v_s1;
	logic                      v_s2;
	logic                      done_q;
	logic [chs_pkg::KEY_W-1:0] key_s1;
	logic [RW-1:0]             quo_s2;
	logic [RW-1:0]             klo_s2;
	logic [BKT_W-1:0]          rem_q;
	logic [PW-1:0]             prod;
	logic [RW-1:0]             rest;
	logic [BKT_W-1:0]          rest_adj;

	// Only the low bits of quotient and key matter: the true remainder fits in RW bits,
	// so the subtraction may wrap at that width.
	assign prod     = {32'd0, key_s1} * {{chs_pkg::KEY_W{1'b0}}, RECIP};
	assign rest     = klo_s2 - quo_s2 * DIV_RW;
	assign rest_adj = (rest >= DIV_RW) ? BKT_W'(rest - DIV_RW) : rest[BKT_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			done_q <= 1'b0;
		end else begin
			v_s1   <= start;
			v_s2   <= v_s1;
			done_q <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (start)
			key_s1 <= key;
		if (v_s1) begin
			quo_s2 <= prod[32 +: RW];
			klo_s2 <= key_s1[RW-1:0];
		end
		if (v_s2)
			rem_q <= rest_adj;
	end

	assign done = done_q;
	assign rem  = rem_q;

endmodule

// ===== src/chs_engine.sv =====
// Table engine: bucket head memory, node memory and the insert/search sequencer.
// Depends on chs_pkg and instantiates chs_bucket.
module chs_engine #(
	parameter int BUCKETS = chs_pkg::DEF_BUCKETS,
	parameter int POOL    = chs_pkg::DEF_POOL
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  chs_pkg::req_t   in_req,
	output logic            res_valid,
	input  logic            res_take,
	output chs_pkg::res_t   res
);

	localparam int BKT_W  = $clog2(BUCKETS);
	localparam int NODE_W = $clog2(POOL + 1);
	localparam int NA_W   = $clog2(POOL);
	localparam logic [NODE_W-1:0] NULL_NODE = NODE_W'(POOL);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_HASH = 3'd1;
	localparam logic [2:0] ST_HEAD = 3'd2;
	localparam logic [2:0] ST_LOOK = 3'd3;
	localparam logic [2:0] ST_RESP = 3'd4;
	localparam logic [2:0] ST_INIT = 3'd5;

	typedef struct packed {
		logic [chs_pkg::KEY_W-1:0] key;
		logic [BKT_W-1:0]          bkt;
		logic [NODE_W-1:0]         link;
	} node_t;

	logic [NODE_W-1:0]          head_mem [BUCKETS];
	node_t                      node_mem [POOL];

	logic [2:0]                 state_q;
	logic [BKT_W-1:0]           init_q;
	logic [chs_pkg::KIND_W-1:0] kind_q;
	logic [chs_pkg::KEY_W-1:0]  key_q;
	logic [NODE_W-1:0]          used_q;
	logic [BKT_W-1:0]           bkt_q;
	logic [NODE_W-1:0]          cur_q;
	logic                       first_q;
	logic                       found_q;
	logic                       status_q;
	logic [NODE_W-1:0]          head_q;
	node_t                      node_q;

	logic                       bkt_start;
	logic                       bkt_done;
	logic [BKT_W-1:0]           bkt_rem;
	logic                       head_lt;
	logic                       bkt_ok;
	logic                       key_hit;
	logic                       link_ok;
	logic                       walk_next;
	logic                       ins_go;
	logic [NODE_W-1:0]          eff_head;
	logic                       node_re;
	logic [NODE_W-1:0]          node_ra;

	chs_bucket #(
		.BUCKETS(BUCKETS)
	) u_bucket (
		.clk   (clk),
		.arst_n(arst_n),
		.start (bkt_start),
		.key   (in_req.key),
		.done  (bkt_done),
		.rem   (bkt_rem)
	);

	assign in_ready  = (state_q == ST_IDLE);
	assign res_valid = (state_q == ST_RESP);
	assign res.found  = found_q;
	assign res.status = status_q;

	assign bkt_start = (state_q == ST_IDLE) && in_valid &&
		((in_req.kind == chs_pkg::KIND_SEARCH) ||
		 ((in_req.kind == chs_pkg::KIND_INSERT) && (used_q != NULL_NODE)));

	// A head is only trusted when it names a node taken since the last clear
	// and that node was filed under the same bucket; anything else is stale.
	assign head_lt = (head_q < used_q);
	assign bkt_ok  = (node_q.bkt == bkt_q);
	assign key_hit = (node_q.key == key_q);
	assign link_ok = (node_q.link < used_q);

	assign walk_next = (state_q == ST_LOOK) && (kind_q == chs_pkg::KIND_SEARCH) &&
		(!first_q || bkt_ok) && !key_hit && link_ok;

	assign ins_go = (kind_q == chs_pkg::KIND_INSERT) &&
		(((state_q == ST_HEAD) && !head_lt) || (state_q == ST_LOOK));

	always_comb begin
		eff_head = NULL_NODE;
		if ((state_q == ST_LOOK) && first_q && bkt_ok)
			eff_head = cur_q;
	end

	always_comb begin
		node_re = 1'b0;
		node_ra = head_q;
		if ((state_q == ST_HEAD) && head_lt) begin
			node_re = 1'b1;
		end else if (walk_next) begin
			node_re = 1'b1;
			node_ra = node_q.link;
		end
	end

	// After reset every head is written once to the empty mark, so that no head
	// is ever read before it holds a known value.
	always_ff @(posedge clk) begin
		if ((state_q == ST_HASH) && bkt_done)
			head_q <= head_mem[bkt_rem];
		if (state_q == ST_INIT)
			head_mem[init_q] <= NULL_NODE;
		else if (ins_go)
			head_mem[bkt_q] <= used_q;
	end

	always_ff @(posedge clk) begin
		if (node_re)
			node_q <= node_mem[node_ra[NA_W-1:0]];
		if (ins_go)
			node_mem[used_q[NA_W-1:0]] <= '{key: key_q, bkt: bkt_q, link: eff_head};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_INIT;
			init_q   <= '0;
			used_q   <= '0;
			kind_q   <= chs_pkg::KIND_INSERT;
			found_q  <= 1'b0;
			status_q <= 1'b0;
			first_q  <= 1'b0;
		end else begin
			case (state_q)
				ST_INIT: begin
					init_q <= init_q + BKT_W'(1);
					if (init_q == BKT_W'(BUCKETS - 1))
						state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (in_valid) begin
						kind_q   <= in_req.kind;
						found_q  <= 1'b0;
						status_q <= 1'b0;
						case (in_req.kind)
							chs_pkg::KIND_INSERT: begin
								if (used_q == NULL_NODE) begin
									status_q <= 1'b1;
									state_q  <= ST_RESP;
								end else begin
									state_q <= ST_HASH;
								end
							end
							chs_pkg::KIND_SEARCH: state_q <= ST_HASH;
							chs_pkg::KIND_CLEAR: begin
								used_q  <= '0;
								state_q <= ST_RESP;
							end
							default: state_q <= ST_RESP;
						endcase
					end
				end
				ST_HASH: begin
					if (bkt_done)
						state_q <= ST_HEAD;
				end
				ST_HEAD: begin
					if (head_lt) begin
						first_q <= 1'b1;
						state_q <= ST_LOOK;
					end else begin
						if (ins_go)
							used_q <= used_q + NODE_W'(1);
						state_q <= ST_RESP;
					end
				end
				ST_LOOK: begin
					if (ins_go) begin
						used_q  <= used_q + NODE_W'(1);
						state_q <= ST_RESP;
					end else if (walk_next) begin
						first_q <= 1'b0;
					end else begin
						found_q <= (!first_q || bkt_ok) && key_hit;
						state_q <= ST_RESP;
					end
				end
				ST_RESP: begin
					if (res_take)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE)
			key_q <= in_req.key;
		if ((state_q == ST_HASH) && bkt_done)
			bkt_q <= bkt_rem;
		if ((state_q == ST_HEAD) && head_lt)
			cur_q <= head_q;
		else if (walk_next)
			cur_q <= node_q.link;
	end

endmodule

// ===== src/chained_hash_set.sv =====
// Top level of the chained hash set: stream ports and the result register.
// Depends on chs_pkg and instantiates chs_engine.
//
// A set of 31-bit keys held as a separate-chaining hash table over a pool of
// POOL nodes, with BUCKETS chains selected by key modulo BUCKETS. Each input
// beat carries a key in s_tdata and an operation in s_tuser: insert pushes the
// key onto the head of its chain (duplicates are kept, and status is raised
// when the pool is used up), search walks the chain and raises found when the
// key is there, and clear empties the whole table at once. Every input beat
// yields exactly one output beat, in order. The block works on one beat at a
// time. After reset it writes every bucket head to the empty mark, with
// s_tready held low. For an insert or a search, the remainder unit first
// finds key modulo BUCKETS by multiplying with a fixed reciprocal and
// correcting once; then the bucket head memory is read, the head is decided
// on, each chain node examined is read from the node memory, and the result
// moves into the output register. A clear, an insert into a full pool or an
// unused operation code goes straight to the result. Clear takes effect at
// once: stale bucket heads are recognised by checking that the node they
// name was taken since the last clear and was filed under the same bucket.
// The result sits in an output register, so a new beat is taken while the
// previous result is still waiting for m_tready.
module chained_hash_set #(
	parameter int BUCKETS = chs_pkg::DEF_BUCKETS,
	parameter int POOL    = chs_pkg::DEF_POOL
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [30:0] key, [31] zero
	input  logic [1:0]  s_tuser,   // [1:0] kind: insert, search, clear
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata    // [0] found, [1] status, [7:2] zero
);

	chs_pkg::req_t in_req;
	chs_pkg::res_t res;
	chs_pkg::res_t res_q;
	logic          res_valid;
	logic          res_take;
	logic          m_tvalid_q;

	assign in_req.kind = s_tuser;
	assign in_req.key  = s_tdata[chs_pkg::KEY_W-1:0];

	chs_engine #(
		.BUCKETS(BUCKETS),
		.POOL   (POOL)
	) u_engine (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_req   (in_req),
		.res_valid(res_valid),
		.res_take (res_take),
		.res      (res)
	);

	// The engine's result moves into the output register whenever that
	// register is empty or is being emptied in the same cycle.
	assign res_take = res_valid && (!m_tvalid_q || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else begin
			if (res_take)
				m_tvalid_q <= 1'b1;
			else if (m_tready)
				m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take)
			res_q <= res;
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {6'd0, res_q.status, res_q.found};

endmodule

// ===== test/chained_hash_set_tb.sv =====
// Self-checking testbench for chained_hash_set: streams insert, search, clear and unused beats
// through the block and checks every result beat against a shadow copy of the hash table.
// Depends on chs_pkg and the chained_hash_set RTL only.
`timescale 1ns / 100ps

module chained_hash_set_tb;
	import chs_pkg::*;

	localparam int N_BUCKETS = DEF_BUCKETS;
	localparam int N_POOL    = DEF_POOL;
	localparam int BEAT_GOAL = 1200;
	// The package names no code for the fourth operation; the block must ignore it.
	localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

	// Shadow of the table: predicts the answer to every accepted request beat and
	// checks the result beats in order against those predictions.
	class hash_set_shadow;
		int unsigned      chain_head [N_BUCKETS];
		logic [KEY_W-1:0] slot_key [N_POOL];
		int unsigned      slot_next [N_POOL];
		int unsigned      slots_taken;
		res_t             pending [$];
		int               mismatches;
		int               n_insert, n_refused, n_search, n_hits, n_clear, n_other;

		function new();
			drop_all();
			mismatches = 0;
			n_insert = 0; n_refused = 0; n_search = 0; n_hits = 0; n_clear = 0; n_other = 0;
		endfunction

		function void drop_all();
			foreach (chain_head[b]) chain_head[b] = N_POOL;
			slots_taken = 0;
		endfunction

		// Works out the answer to one request and updates the shadow table.
		function res_t answer_for(logic [KIND_W-1:0] kind, logic [KEY_W-1:0] key);
			res_t        r;
			int unsigned b, node, steps;
			r = '0;
			b = key % N_BUCKETS;
			case (kind)
			KIND_INSERT: begin
				n_insert++;
				if (slots_taken >= N_POOL) begin
					r.status = 1'b1;
					n_refused++;
				end else begin
					slot_key[slots_taken]  = key;
					slot_next[slots_taken] = chain_head[b];
					chain_head[b] = slots_taken;
					slots_taken++;
				end
			end
			KIND_SEARCH: begin
				n_search++;
				node  = chain_head[b];
				steps = 0;
				while (node < N_POOL && steps < N_POOL) begin
					if (slot_key[node] == key) begin
						r.found = 1'b1;
						break;
					end
					node = slot_next[node];
					steps++;
				end
				if (r.found) n_hits++;
			end
			KIND_CLEAR: begin
				n_clear++;
				drop_all();
			end
			default: n_other++;
			endcase
			return r;
		endfunction

		function void take_request(logic [KIND_W-1:0] kind, logic [KEY_W-1:0] key);
			pending.push_back(answer_for(kind, key));
		endfunction

		function void check_answer(logic [7:0] tdata);
			res_t want;
			if (pending.size() == 0) begin
				$error("result beat 0x%02h arrived with no request outstanding", tdata);
				mismatches++;
				return;
			end
			want = pending.pop_front();
			if (tdata[0] !== want.found) begin
				$error("found: expected %0b, got %0b", want.found, tdata[0]);
				mismatches++;
			end
			if (tdata[1] !== want.status) begin
				$error("status: expected %0b, got %0b", want.status, tdata[1]);
				mismatches++;
			end
			if (tdata[7:2] !== 6'd0) begin
				$error("m_tdata[7:2]: expected 0, got %b", tdata[7:2]);
				mismatches++;
			end
		endfunction
	endclass

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata  = '0;
	logic [1:0]  s_tuser  = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;

	hash_set_shadow   shadow;
	// When set, neither side idles: back-to-back beats for a whole stretch of traffic.
	bit               calm = 1'b0;
	int               beats_sent = 0;
	// Keys inserted since the last clear, and keys that a clear should have wiped.
	logic [KEY_W-1:0] live_keys [$];
	logic [KEY_W-1:0] stale_keys [$];

	chained_hash_set dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// The worst case for a beat is a full-length chain walk plus both stalls; this
	// leaves several times that for the whole run.
	initial begin
		#5_000_000;
		$display("[chained_hash_set] ERROR");
		$finish;
	end

	// A key for an insert or a miss. Some keys crowd into three buckets so that chains
	// grow long, some sit at the extremes, and some differ from a stored key in one bit.
	function automatic logic [KEY_W-1:0] fresh_key();
		int               sel;
		logic [KEY_W-1:0] k;
		sel = $urandom_range(0, 9);
		k   = KEY_W'($urandom());
		case (sel)
		4, 5: k = KEY_W'($urandom_range(0, 63));
		6, 7: k = k - KEY_W'(k % N_BUCKETS) + KEY_W'($urandom_range(0, 2));
		8: begin
			case ($urandom_range(0, 3))
			0:       k = '0;
			1:       k = '1;
			2:       k = {1'b1, {(KEY_W-1){1'b0}}};
			default: k = KEY_W'(N_BUCKETS - 1);
			endcase
		end
		9: begin
			if (live_keys.size() != 0)
				k = live_keys[$urandom_range(0, live_keys.size() - 1)] ^
					(KEY_W'(1) << $urandom_range(0, KEY_W - 1));
		end
		default: ;
		endcase
		return k;
	endfunction

	// Searches mostly ask for keys that are stored, some for keys wiped by a clear.
	function automatic logic [KEY_W-1:0] search_key();
		int sel;
		sel = $urandom_range(0, 9);
		if (sel < 5 && live_keys.size() != 0)
			return live_keys[$urandom_range(0, live_keys.size() - 1)];
		if (sel < 7 && stale_keys.size() != 0)
			return stale_keys[$urandom_range(0, stale_keys.size() - 1)];
		return fresh_key();
	endfunction

	// Offers one request beat, entered and left at a falling edge. The valid is only
	// lowered when a gap is drawn, so back-to-back beats keep it high.
	task automatic send_beat(input logic [KIND_W-1:0] kind, input logic [KEY_W-1:0] key);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 14);
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {1'b0, key};
		s_tuser  <= kind;
		do @(posedge clk); while (s_tready !== 1'b1);
		shadow.take_request(kind, key);
		@(negedge clk);
	endtask

	// Keeps the stimulus' own record of keys in step with the table, then sends the beat.
	task automatic issue(input logic [KIND_W-1:0] kind, input logic [KEY_W-1:0] key);
		if (kind == KIND_INSERT) begin
			live_keys.push_back(key);
			if (live_keys.size() > 96) void'(live_keys.pop_front());
		end else if (kind == KIND_CLEAR) begin
			foreach (live_keys[i]) stale_keys.push_back(live_keys[i]);
			live_keys.delete();
			while (stale_keys.size() > 64) void'(stale_keys.pop_front());
		end
		beats_sent++;
		send_beat(kind, key);
	endtask

	// Holds the sender off until every outstanding result beat has been taken.
	task automatic drain_results();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (shadow.pending.size() != 0);
		@(negedge clk);
	endtask

	initial begin
		int len, sel;
		shadow = new();

		// Result side: a random stall before every beat, none while the traffic is calm.
		fork
			forever begin
				int gap;
				gap = calm ? 0 : $urandom_range(0, 14);
				if (gap != 0) begin
					m_tready <= 1'b0;
					repeat (gap) @(negedge clk);
				end
				m_tready <= 1'b1;
				do @(posedge clk); while (m_tvalid !== 1'b1);
				shadow.check_answer(m_tdata);
				@(negedge clk);
			end
		join_none

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		// Directed part: an empty table, extreme keys, a chain of several nodes with a
		// duplicate, misses in an occupied bucket, the unused operation, and searches
		// after a clear, when the bucket heads still name nodes from before it.
		issue(KIND_SEARCH, '0);
		issue(KIND_INSERT, '0);
		issue(KIND_INSERT, '1);
		issue(KIND_SEARCH, '0);
		issue(KIND_SEARCH, '1);
		issue(KIND_SEARCH, 31'h7FFF_FFEF);
		issue(KIND_INSERT, 31'd16);
		issue(KIND_INSERT, '0);
		issue(KIND_SEARCH, 31'd16);
		issue(KIND_SEARCH, 31'd32);
		issue(KIND_UNUSED, '1);
		issue(KIND_UNUSED, '0);
		issue(KIND_SEARCH, '0);
		issue(KIND_CLEAR, '1);
		issue(KIND_SEARCH, '0);
		issue(KIND_SEARCH, '1);
		issue(KIND_INSERT, 31'd5);
		issue(KIND_SEARCH, 31'd5);
		issue(KIND_INSERT, 31'h5555_5555);
		issue(KIND_INSERT, 31'h2AAA_AAAA);
		issue(KIND_SEARCH, 31'h5555_5555);
		issue(KIND_SEARCH, 31'h2AAA_AAAA);
		issue(KIND_CLEAR, '0);
		drain_results();
		issue(KIND_SEARCH, 31'd5);

		// Random part, in stretches. A filling stretch runs the pool past full so that
		// inserts are refused and chains get long; the others mix every operation.
		while (beats_sent < BEAT_GOAL) begin
			calm = ($urandom_range(0, 4) == 0);
			if ($urandom_range(0, 4) == 0) drain_results();
			if ($urandom_range(0, 9) < 2) begin
				if ($urandom_range(0, 1) == 0) issue(KIND_CLEAR, fresh_key());
				for (int i = 0; i < N_POOL + 6; i++) begin
					issue(KIND_INSERT, fresh_key());
					if ($urandom_range(0, 3) == 0) issue(KIND_SEARCH, search_key());
				end
				repeat ($urandom_range(3, 12)) issue(KIND_SEARCH, search_key());
			end else begin
				len = $urandom_range(5, 40);
				repeat (len) begin
					sel = $urandom_range(0, 19);
					if (sel < 9)
						issue(KIND_INSERT, fresh_key());
					else if (sel < 18)
						issue(KIND_SEARCH, search_key());
					else if (sel == 18)
						issue(KIND_CLEAR, fresh_key());
					else
						issue(KIND_UNUSED, fresh_key());
				end
			end
		end

		s_tvalid <= 1'b0;
		do @(posedge clk); while (shadow.pending.size() != 0);
		// Long enough for a stray beat from the slowest chain walk to show up.
		repeat (100) @(posedge clk);

		$display("Run covered %0d inserts (%0d refused on a full pool), %0d searches (%0d hits),",
			shadow.n_insert, shadow.n_refused, shadow.n_search, shadow.n_hits);
		$display("%0d clears and %0d beats of the unused operation; %0d mismatches.",
			shadow.n_clear, shadow.n_other, shadow.mismatches);
		if (shadow.mismatches == 0) begin
			$display("[chained_hash_set] OK");
		end else begin
			$display("[chained_hash_set] ERROR");
		end
		$finish;
	end

endmodule

// ===== files.f =====
src/chs_pkg.sv
src/chs_bucket.sv
src/chs_engine.sv
src/chained_hash_set.sv
test/chained_hash_set_tb.sv
